// ===== hw/rtl/spt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the skin partition triangle parser.
// No dependencies; imported by every module of the block.
package spt_pkg;

  // Word on the input channel: one raw table byte plus end-of-table mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // Word on the result channel.
  typedef struct packed {
    logic        kind;
    logic [15:0] vertex_a;
    logic [15:0] vertex_b;
    logic [15:0] vertex_c;
    logic        truncated;
  } out_word_t;

  // Entry of the byte queue between front and parser, already classified.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       byte_nz;
  } byte_ent_t;

  // Configuration registers as seen by the parser.
  typedef struct packed {
    logic [15:0] partition_count;
    logic [15:0] vertex_count;
  } cfg_t;

  localparam logic KIND_TRI = 1'b0;
  localparam logic KIND_END = 1'b1;

  // Register index (byte address bit 2).
  localparam logic REG_PARTITION_COUNT = 1'b0;
  localparam logic REG_VERTEX_COUNT    = 1'b1;

  localparam int unsigned SKIP_W = 34;

  localparam logic [SKIP_W-1:0] HDR_BYTES  = 34'd2;
  localparam logic [SKIP_W-1:0] TRI_BYTES  = 34'd6;
  localparam logic [SKIP_W-1:0] TAIL_BYTES = 34'd10;

endpackage

// ===== hw/rtl/skin_partition_triangle_parser.sv =====
`timescale 1ns / 1ps
// Top level of the skin partition triangle parser: register port, byte
// front end, parser and result queue. Depends on spt_pkg and its submodules.
//
//  channel   | dir | handshake                 | word
//  ----------+-----+---------------------------+-----------------------------
//  in_       | in  | in_valid / in_stall       | in_word_t: data_byte, last_byte
//  out_      | out | out_valid / out_stall     | out_word_t: kind, vertex_a..c,
//            |     |                           |   truncated
//  register  | in  | psel/penable/pwrite/pready| 0x0 partition_count,
//            |     |                           | 0x4 vertex_count (16 bits each)
//
// Cycles: one byte per clock sustained while neither queue is full; the
//   parser takes one queued byte per cycle while the result queue has
//   room, bounded by its single state update per byte. A result word is
//   registered in the front queue, then the result queue, before out_ shows it.
//   A closing byte that completes a triangle yields two words back to back.
// Reset: rst_n is synchronous, active low; clears queues and parser state,
//   registers read zero.
// Stalls: the front queue absorbs in_ words while the parser waits; the
//   parser only takes a byte when the result queue has room for two words.
module skin_partition_triangle_parser import spt_pkg::*; #(
  parameter int IN_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,

  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic       reg_sel;

  byte_ent_t  ent;
  logic       ent_valid;
  logic       ent_pop;
  logic       res_room;
  out_word_t  res0;
  out_word_t  res1;
  logic [1:0] res_cnt;

  // Register port: write completes on the access cycle; bit 2 picks the
  // register, so every write lands in one of the two.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = (reg_sel == REG_VERTEX_COUNT) ? {16'd0, cfg_r.vertex_count}
                                                 : {16'd0, cfg_r.partition_count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      if (reg_sel == REG_PARTITION_COUNT) begin
        cfg_r.partition_count <= pwdata[15:0];
      end else begin
        cfg_r.vertex_count <= pwdata[15:0];
      end
    end
  end

  // front: accept and classify bytes into a short queue
  spt_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .ent_valid (ent_valid),
    .ent       (ent),
    .ent_pop   (ent_pop)
  );

  // back: partition walk, region skipping, triangle checks
  spt_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ent_valid (ent_valid),
    .ent       (ent),
    .ent_pop   (ent_pop),
    .res_room  (res_room),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt)
  );

  // results wait here so the parser never sees out_stall directly
  spt_result_queue u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt),
    .res_room  (res_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/spt_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts table bytes, flags nonzero bytes, and queues them.
// Depends on spt_pkg.
module spt_front import spt_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      ent_valid,
  output byte_ent_t ent,
  input  logic      ent_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  byte_ent_t         mem [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              push;
  logic              pop;

  assign in_stall  = (cnt_r == CW'(DEPTH));
  assign ent_valid = (cnt_r != '0);
  assign ent       = mem[rd_ptr_r];
  assign push      = in_valid & ~in_stall;
  assign pop       = ent_pop & ent_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // classify on the way in: flag bytes only care about zero / nonzero
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= '{data_byte: in_data.data_byte,
                         last_byte: in_data.last_byte,
                         byte_nz:   |in_data.data_byte};
    end
  end

endmodule

// ===== hw/rtl/spt_parser.sv =====
`timescale 1ns / 1ps
// Back end: partition table parser, one queued byte per cycle while the result
// queue has room, up to two results per byte. Depends on spt_pkg.
module spt_parser import spt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       ent_valid,
  input  byte_ent_t  ent,
  output logic       ent_pop,
  input  logic       res_room,
  output out_word_t  res0,
  output out_word_t  res1,
  output logic [1:0] res_cnt
);

  typedef enum logic [3:0] {
    PH_VERTS, PH_TRIS_CNT, PH_BONES_CNT, PH_STRIPS_CNT, PH_WGTS_CNT,
    PH_BONES, PH_VMAP_FLAG, PH_VMAP, PH_WGT_FLAG, PH_WGT, PH_STRIPS,
    PH_FACE_FLAG, PH_FACES, PH_BIDX_FLAG, PH_TAIL, PH_TRIS
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [7:0]         low_r, low_nxt;
  logic [15:0]        vert_r, vert_nxt;
  logic [15:0]        tris_r, tris_nxt;
  logic [15:0]        strips_r, strips_nxt;
  logic [15:0]        wgt_r, wgt_nxt;
  logic [SKIP_W-1:0]  skip_r, skip_nxt;
  logic [15:0]        pidx_r, pidx_nxt;
  logic [15:0]        tidx_r, tidx_nxt;
  logic [15:0]        held_a_r, held_a_nxt;   // also holds bone count
  logic [15:0]        held_b_r, held_b_nxt;
  logic               done_r, done_nxt;

  logic [31:0]        vw;
  logic [SKIP_W-1:0]  tris_x6;
  logic [SKIP_W-1:0]  skip_dec;
  logic [15:0]        word16;
  logic [15:0]        pidx_inc;
  logic [15:0]        tidx_inc;
  logic               ent_go;
  phase_t             ent_tgt;
  phase_t             p;
  logic               fin;
  logic               tri_emit;
  logic               end_emit;
  logic               trunc;

  assign vw       = vert_r * wgt_r;
  assign tris_x6  = ({18'd0, tris_r} << 2) + ({18'd0, tris_r} << 1);
  assign skip_dec = skip_r - 34'd1;
  assign word16   = {ent.data_byte, low_r};
  assign pidx_inc = pidx_r + 16'd1;
  assign tidx_inc = tidx_r + 16'd1;
  assign ent_pop  = ent_valid & res_room;

  always_comb begin
    phase_nxt  = phase_r;
    low_nxt    = low_r;
    vert_nxt   = vert_r;
    tris_nxt   = tris_r;
    strips_nxt = strips_r;
    wgt_nxt    = wgt_r;
    skip_nxt   = skip_r;
    pidx_nxt   = pidx_r;
    tidx_nxt   = tidx_r;
    held_a_nxt = held_a_r;
    held_b_nxt = held_b_r;
    done_nxt   = done_r;
    ent_go     = 1'b0;
    ent_tgt    = phase_r;
    p          = phase_r;
    fin        = 1'b0;
    tri_emit   = 1'b0;
    end_emit   = 1'b0;
    trunc      = 1'b0;

    if (!done_r) begin
      if (phase_r == PH_VERTS && skip_r == HDR_BYTES &&
          pidx_r >= cfg.partition_count) begin
        done_nxt = 1'b1;
      end else begin
        case (phase_r)
          PH_VERTS, PH_TRIS_CNT, PH_BONES_CNT, PH_STRIPS_CNT, PH_WGTS_CNT: begin
            if (skip_r == HDR_BYTES) begin
              low_nxt  = ent.data_byte;
              skip_nxt = 34'd1;
            end else begin
              case (phase_r)
                PH_VERTS:      vert_nxt   = word16;
                PH_TRIS_CNT:   tris_nxt   = word16;
                PH_BONES_CNT:  held_a_nxt = word16;
                PH_STRIPS_CNT: strips_nxt = word16;
                default:       wgt_nxt    = word16;
              endcase
              if (phase_r == PH_WGTS_CNT) begin
                ent_go  = 1'b1;
                ent_tgt = PH_BONES;
              end else begin
                phase_nxt = phase_t'(phase_r + 4'd1);
                skip_nxt  = HDR_BYTES;
              end
            end
          end
          PH_VMAP_FLAG: begin
            ent_go  = 1'b1;
            ent_tgt = ent.byte_nz ? PH_VMAP : PH_WGT_FLAG;
          end
          PH_WGT_FLAG: begin
            ent_go  = 1'b1;
            ent_tgt = ent.byte_nz ? PH_WGT : PH_STRIPS;
          end
          PH_FACE_FLAG: begin
            ent_go  = 1'b1;
            ent_tgt = (ent.byte_nz && strips_r == 16'd0) ? PH_FACES : PH_BIDX_FLAG;
          end
          PH_BIDX_FLAG: begin
            skip_nxt  = (ent.byte_nz ? {2'b00, vw} : '0) + TAIL_BYTES;
            phase_nxt = PH_TAIL;
          end
          PH_TRIS: begin
            // skip counts 6..1 over the triple: odd counts complete a word
            if (skip_r == 34'd5) begin
              held_a_nxt = word16;
            end else if (skip_r == 34'd3) begin
              held_b_nxt = word16;
            end else if (skip_r == 34'd1) begin
              tri_emit = (held_a_r < cfg.vertex_count) &&
                         (held_b_r < cfg.vertex_count) &&
                         (word16 < cfg.vertex_count);
            end else begin
              low_nxt = ent.data_byte;
            end
            skip_nxt = skip_dec;
            if (skip_dec == '0) begin
              tidx_nxt = tidx_inc;
              if (tidx_inc >= tris_r) begin
                fin = 1'b1;
              end else begin
                skip_nxt = TRI_BYTES;
              end
            end
          end
          default: begin
            // plain skip regions
            skip_nxt = skip_dec;
            if (skip_dec == '0) begin
              ent_go = 1'b1;
              case (phase_r)
                PH_BONES:  ent_tgt = PH_VMAP_FLAG;
                PH_VMAP:   ent_tgt = PH_WGT_FLAG;
                PH_WGT:    ent_tgt = PH_STRIPS;
                PH_STRIPS: ent_tgt = PH_FACE_FLAG;
                PH_FACES:  ent_tgt = PH_BIDX_FLAG;
                default:   ent_tgt = PH_TRIS;
              endcase
            end
          end
        endcase
      end
    end

    // region entry: empty regions fall through to the next phase
    if (ent_go) begin
      p = ent_tgt;
      if (p == PH_BONES) begin
        if (held_a_r != 16'd0) skip_nxt = {17'd0, held_a_r, 1'b0};
        else p = PH_VMAP_FLAG;
      end
      if (p == PH_VMAP) begin
        if (vert_r != 16'd0) skip_nxt = {17'd0, vert_r, 1'b0};
        else p = PH_WGT_FLAG;
      end
      if (p == PH_WGT) begin
        if (vw != 32'd0) skip_nxt = {vw, 2'b00};
        else p = PH_STRIPS;
      end
      if (p == PH_STRIPS) begin
        if (strips_r != 16'd0) skip_nxt = {17'd0, strips_r, 1'b0};
        else p = PH_FACE_FLAG;
      end
      if (p == PH_FACES) begin
        if (tris_r != 16'd0) skip_nxt = tris_x6;
        else p = PH_BIDX_FLAG;
      end
      if (p == PH_TRIS) begin
        tidx_nxt = 16'd0;
        if (tris_r == 16'd0) fin = 1'b1;
        else skip_nxt = TRI_BYTES;
      end
      phase_nxt = p;
    end

    if (fin) begin
      pidx_nxt  = pidx_inc;
      done_nxt  = done_nxt | (pidx_inc >= cfg.partition_count);
      phase_nxt = PH_VERTS;
      skip_nxt  = HDR_BYTES;
    end

    if (ent.last_byte) begin
      end_emit   = 1'b1;
      trunc      = !done_nxt && !(phase_nxt == PH_VERTS && skip_nxt == HDR_BYTES);
      phase_nxt  = PH_VERTS;
      low_nxt    = '0;
      vert_nxt   = '0;
      tris_nxt   = '0;
      strips_nxt = '0;
      wgt_nxt    = '0;
      skip_nxt   = HDR_BYTES;
      pidx_nxt   = '0;
      tidx_nxt   = '0;
      held_a_nxt = '0;
      held_b_nxt = '0;
      done_nxt   = 1'b0;
    end
  end

  out_word_t tri_word;
  out_word_t end_word;

  assign tri_word = '{kind: KIND_TRI, vertex_a: held_a_r, vertex_b: held_b_r,
                      vertex_c: word16, truncated: 1'b0};
  assign end_word = '{kind: KIND_END, vertex_a: 16'd0, vertex_b: 16'd0,
                      vertex_c: 16'd0, truncated: trunc};

  // triangle always goes ahead of the end report
  assign res0    = tri_emit ? tri_word : end_word;
  assign res1    = end_word;
  assign res_cnt = ent_pop ? ({1'b0, tri_emit} + {1'b0, end_emit}) : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_VERTS;
      low_r    <= '0;
      vert_r   <= '0;
      tris_r   <= '0;
      strips_r <= '0;
      wgt_r    <= '0;
      skip_r   <= HDR_BYTES;
      pidx_r   <= '0;
      tidx_r   <= '0;
      held_a_r <= '0;
      held_b_r <= '0;
      done_r   <= 1'b0;
    end else if (ent_pop) begin
      phase_r  <= phase_nxt;
      low_r    <= low_nxt;
      vert_r   <= vert_nxt;
      tris_r   <= tris_nxt;
      strips_r <= strips_nxt;
      wgt_r    <= wgt_nxt;
      skip_r   <= skip_nxt;
      pidx_r   <= pidx_nxt;
      tidx_r   <= tidx_nxt;
      held_a_r <= held_a_nxt;
      held_b_r <= held_b_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

// ===== hw/rtl/spt_result_queue.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two words per cycle from the parser and
// hands them out one per cycle while out_stall is low. Depends on spt_pkg.
module spt_result_queue import spt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  out_word_t  res0,
  input  out_word_t  res1,
  input  logic [1:0] res_cnt,
  output logic       res_room,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  out_word_t      mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid & ~out_stall;
  assign res_room  = (cnt_r <= CW'(DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(res_cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(res_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_cnt != 2'd0) begin
      mem[wr_ptr_r] <= res0;
    end
    if (res_cnt == 2'd2) begin
      mem[wr_ptr_r + PW'(1)] <= res1;
    end
  end

endmodule

// ===== verif/tb_skin_partition_triangle_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for skin_partition_triangle_parser: a directed partition
// table, then random tables checked against a built-in parser model.
// Depends on spt_pkg and the RTL of the block only.
module tb_skin_partition_triangle_parser;
  import spt_pkg::*;

  localparam int RANDOM_ITEMS = 1350;
  localparam int QUIET_ITEMS  = 200;   // closing stretch with no idling on either side
  localparam int HOLD_CYCLES  = 150;   // long receiver hold-off, fills the block
  localparam int SETTLE       = 16;    // front queue + result queue, with margin

  // Parser phases: five header count fields, then the skipped regions, flags,
  // fixed tail and the triangle triples.
  localparam logic [3:0] P_VERTS_FIELD   = 4'd0;
  localparam logic [3:0] P_TRIS_FIELD    = 4'd1;
  localparam logic [3:0] P_BONES_FIELD   = 4'd2;
  localparam logic [3:0] P_STRIPS_FIELD  = 4'd3;
  localparam logic [3:0] P_WEIGHTS_FIELD = 4'd4;
  localparam logic [3:0] P_BONE_LIST     = 4'd5;
  localparam logic [3:0] P_VMAP_FLAG     = 4'd6;
  localparam logic [3:0] P_VMAP          = 4'd7;
  localparam logic [3:0] P_WGT_FLAG      = 4'd8;
  localparam logic [3:0] P_WGT           = 4'd9;
  localparam logic [3:0] P_STRIP_LENS    = 4'd10;
  localparam logic [3:0] P_FACE_FLAG     = 4'd11;
  localparam logic [3:0] P_FACES         = 4'd12;
  localparam logic [3:0] P_BIDX_FLAG     = 4'd13;
  localparam logic [3:0] P_TAIL          = 4'd14;
  localparam logic [3:0] P_TRIANGLES     = 4'd15;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  skin_partition_triangle_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("tb_skin_partition_triangle_parser: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Parser model: register copies and parse state
  // ---------------------------------------------------------------------------
  logic [15:0]       cfg_parts;
  logic [15:0]       cfg_verts;

  logic [3:0]        ps_phase;
  logic [7:0]        ps_low;
  logic [15:0]       ps_verts;
  logic [15:0]       ps_tris;
  logic [15:0]       ps_strips;
  logic [15:0]       ps_wpv;
  logic [SKIP_W-1:0] ps_skip;
  logic [15:0]       ps_part;
  logic [15:0]       ps_tri;
  logic [15:0]       ps_first;   // also holds the bone count until the bone list
  logic [15:0]       ps_second;
  bit                ps_faces;
  bit                ps_done;

  out_word_t step_words[$];      // words caused by the byte just taken
  out_word_t awaited_words[$];   // words the block still owes, oldest first
  int        mismatch_count;

  bit quiet;          // no idling on either side
  bit sender_gaps;    // idling allowed on the input side for this table
  bit hold_results;   // request for one long receiver hold-off

  function automatic void clear_parse_state();
    ps_phase  = P_VERTS_FIELD;
    ps_low    = '0;
    ps_verts  = '0;
    ps_tris   = '0;
    ps_strips = '0;
    ps_wpv    = '0;
    ps_skip   = HDR_BYTES;
    ps_part   = '0;
    ps_tri    = '0;
    ps_first  = '0;
    ps_second = '0;
    ps_faces  = 1'b0;
    ps_done   = 1'b0;
  endfunction

  function automatic void close_partition();
    ps_part = ps_part + 16'd1;
    if (ps_part >= cfg_parts) ps_done = 1'b1;
    ps_phase = P_VERTS_FIELD;
    ps_skip  = HDR_BYTES;
  endfunction

  // Move to a region; regions of zero length fall through to the next phase
  // without taking a byte.
  function automatic void enter_region(input logic [3:0] target);
    logic [3:0]        p;
    bit                more;
    logic [SKIP_W-1:0] nb, nv, nw, ns, nt;
    p  = target;
    more = 1'b1;
    nb = ps_first;
    nv = ps_verts;
    nw = ps_wpv;
    ns = ps_strips;
    nt = ps_tris;
    while (more) begin
      ps_phase = p;
      more = 1'b0;
      case (p)
        P_BONE_LIST: begin
          ps_skip = nb * 2;
          if (ps_skip == 0) begin p = P_VMAP_FLAG; more = 1'b1; end
        end
        P_VMAP: begin
          ps_skip = nv * 2;
          if (ps_skip == 0) begin p = P_WGT_FLAG; more = 1'b1; end
        end
        P_WGT: begin
          ps_skip = nv * nw * 4;
          if (ps_skip == 0) begin p = P_STRIP_LENS; more = 1'b1; end
        end
        P_STRIP_LENS: begin
          ps_skip = ns * 2;
          if (ps_skip == 0) begin p = P_FACE_FLAG; more = 1'b1; end
        end
        P_FACES: begin
          ps_skip = nt * TRI_BYTES;
          if (ps_skip == 0) begin p = P_BIDX_FLAG; more = 1'b1; end
        end
        P_TRIANGLES: begin
          ps_tri = '0;
          if (ps_tris == 0) close_partition();
          else ps_skip = TRI_BYTES;
        end
        default: ;
      endcase
    end
  endfunction

  // Advance the model by one table byte; any words it causes go to step_words.
  function automatic void parse_byte(input in_word_t w);
    logic [7:0]        b;
    logic [15:0]       v;
    logic [SKIP_W-1:0] pos, nv, nw;
    out_word_t         r;
    bit                at_boundary;
    b  = w.data_byte;
    v  = {b, ps_low};
    nv = ps_verts;
    nw = ps_wpv;
    if (ps_done) begin
      // table finished: byte ignored
    end else if (ps_phase == P_VERTS_FIELD && ps_skip == HDR_BYTES && ps_part >= cfg_parts) begin
      ps_done = 1'b1;
    end else if (ps_phase <= P_WEIGHTS_FIELD) begin
      if (ps_skip == HDR_BYTES) begin
        ps_low  = b;
        ps_skip = SKIP_W'(1);
      end else begin
        case (ps_phase)
          P_VERTS_FIELD:  ps_verts  = v;
          P_TRIS_FIELD:   ps_tris   = v;
          P_BONES_FIELD:  ps_first  = v;
          P_STRIPS_FIELD: ps_strips = v;
          default:        ps_wpv    = v;
        endcase
        if (ps_phase < P_WEIGHTS_FIELD) begin
          ps_phase = ps_phase + 4'd1;
          ps_skip  = HDR_BYTES;
        end else begin
          enter_region(P_BONE_LIST);
        end
      end
    end else begin
      case (ps_phase)
        P_VMAP_FLAG: enter_region((b != 0) ? P_VMAP : P_WGT_FLAG);
        P_WGT_FLAG:  enter_region((b != 0) ? P_WGT : P_STRIP_LENS);
        P_FACE_FLAG: begin
          ps_faces = (b != 0);
          enter_region((ps_faces && ps_strips == 0) ? P_FACES : P_BIDX_FLAG);
        end
        P_BIDX_FLAG: begin
          if (b != 0) ps_skip = nv * nw + TAIL_BYTES;
          else ps_skip = TAIL_BYTES;
          ps_phase = P_TAIL;
        end
        P_TRIANGLES: begin
          pos = TRI_BYTES - ps_skip;
          if (!pos[0]) begin
            ps_low = b;
          end else if (pos == 1) begin
            ps_first = v;
          end else if (pos == 3) begin
            ps_second = v;
          end else if (ps_first < cfg_verts && ps_second < cfg_verts && v < cfg_verts) begin
            r = '0;
            r.kind     = KIND_TRI;
            r.vertex_a = ps_first;
            r.vertex_b = ps_second;
            r.vertex_c = v;
            step_words.insert(step_words.size(), r);
          end
          ps_skip = ps_skip - 1;
          if (ps_skip == 0) begin
            ps_tri = ps_tri + 16'd1;
            if (ps_tri >= ps_tris) close_partition();
            else ps_skip = TRI_BYTES;
          end
        end
        default: begin
          ps_skip = ps_skip - 1;
          if (ps_skip == 0) begin
            case (ps_phase)
              P_BONE_LIST:  enter_region(P_VMAP_FLAG);
              P_VMAP:       enter_region(P_WGT_FLAG);
              P_WGT:        enter_region(P_STRIP_LENS);
              P_STRIP_LENS: enter_region(P_FACE_FLAG);
              P_FACES:      enter_region(P_BIDX_FLAG);
              default:      enter_region(P_TRIANGLES);
            endcase
          end
        end
      endcase
    end
    // End of table: report, then start over with registers kept.
    if (w.last_byte) begin
      at_boundary = (ps_phase == P_VERTS_FIELD && ps_skip == HDR_BYTES);
      r = '0;
      r.kind      = KIND_END;
      r.truncated = !ps_done && !at_boundary;
      step_words.insert(step_words.size(), r);
      clear_parse_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // APB write: setup cycle, then access until pready. The model copy changes
  // at the same edge as the block's register.
  task automatic cfg_write(input logic reg_sel, input logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_PARTITION_COUNT) cfg_parts = value;
    else cfg_verts = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one word and hold it until taken; then the model predicts what it causes.
  // A typed row replaces the last predicted word with the value read off the table.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_word);
    if (!quiet && sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    step_words.delete();
    parse_byte(w);
    if (typed && step_words.size() != 0) step_words[step_words.size() - 1] = typed_word;
    foreach (step_words[i]) awaited_words.insert(awaited_words.size(), step_words[i]);
  endtask

  // Input side goes quiet, every owed word arrives, then the front queue may
  // still hold bytes that cause nothing: let it settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random table construction
  // ---------------------------------------------------------------------------
  in_word_t table_words[$];

  function automatic void push_byte(input logic [7:0] d);
    in_word_t w;
    w.data_byte = d;
    w.last_byte = 1'b0;
    table_words.insert(table_words.size(), w);
  endfunction

  function automatic void push_count(input logic [15:0] v);
    push_byte(v[7:0]);
    push_byte(v[15:8]);
  endfunction

  function automatic void push_flag(input bit f);
    push_byte(f ? 8'($urandom_range(1, 255)) : 8'h00);
  endfunction

  // Mostly indices below vertex_count, plus the boundary, the top value and a random value.
  function automatic logic [15:0] pick_index();
    case ($urandom_range(0, 5))
      0:       return 16'hFFFF;
      1:       return cfg_verts;
      2:       return 16'($urandom);
      default: return (cfg_verts == 0) ? 16'h0000 : 16'($urandom_range(0, cfg_verts - 1));
    endcase
  endfunction

  // One well-formed partition with small region sizes. Now and then the
  // vertex count is a full 16-bit value, with every region that scales by it
  // switched off so the partition stays short.
  function automatic void build_partition();
    int  verts, tris, bones, strips, wpv;
    bit  wide, vmap, wgt, faces, bidx;
    wide   = ($urandom_range(0, 15) == 0);
    verts  = wide ? $urandom_range(0, 65535) : $urandom_range(0, 6);
    tris   = $urandom_range(0, 4);
    bones  = $urandom_range(0, 3);
    strips = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
    wpv    = $urandom_range(0, 3);
    vmap   = !wide && $urandom_range(0, 1);
    wgt    = !wide && $urandom_range(0, 1);
    faces  = $urandom_range(0, 1);
    bidx   = !wide && $urandom_range(0, 1);
    push_count(16'(verts));
    push_count(16'(tris));
    push_count(16'(bones));
    push_count(16'(strips));
    push_count(16'(wpv));
    repeat (bones * 2) push_byte(8'($urandom));
    push_flag(vmap);
    if (vmap) repeat (verts * 2) push_byte(8'($urandom));
    push_flag(wgt);
    if (wgt) repeat (verts * wpv * 4) push_byte(8'($urandom));
    repeat (strips * 2) push_byte(8'($urandom));
    push_flag(faces);
    if (faces && strips == 0) repeat (tris * 6) push_byte(8'($urandom));
    push_flag(bidx);
    if (bidx) repeat (verts * wpv) push_byte(8'($urandom));
    repeat (10) push_byte(8'($urandom));
    repeat (tris) begin
      push_count(pick_index());
      push_count(pick_index());
      push_count(pick_index());
    end
  endfunction

  // Build one table; returns the number of bytes that are not trailing junk.
  function automatic int build_table();
    int nparts, mode, body, cut;
    table_words.delete();
    if (cfg_parts <= 4) nparts = cfg_parts + (($urandom_range(0, 3) == 0) ? 1 : 0);
    else nparts = $urandom_range(0, 3);
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      // plain noise
      repeat ($urandom_range(1, 30)) push_byte(8'($urandom));
    end else begin
      repeat (nparts) build_partition();
      if (mode == 1 && table_words.size() > 1) begin
        cut = $urandom_range(1, table_words.size() - 1);
        repeat (cut) void'(table_words.pop_back());
      end
    end
    body = table_words.size();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
    if (table_words.size() == 0) push_byte(8'($urandom));
    table_words[table_words.size() - 1].last_byte = 1'b1;
    return body;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every taken result word with the oldest owed word.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_words.size() == 0) begin
        $error("result word with nothing owed: kind %0h a %0h b %0h c %0h trunc %0h",
               out_data.kind, out_data.vertex_a, out_data.vertex_b,
               out_data.vertex_c, out_data.truncated);
        mismatch_count++;
      end else begin
        out_word_t want;
        want = awaited_words.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("field kind: expected %0h, got %0h", want.kind, out_data.kind);
          mismatch_count++;
        end
        if (out_data.vertex_a !== want.vertex_a) begin
          $error("field vertex_a: expected %0h, got %0h", want.vertex_a, out_data.vertex_a);
          mismatch_count++;
        end
        if (out_data.vertex_b !== want.vertex_b) begin
          $error("field vertex_b: expected %0h, got %0h", want.vertex_b, out_data.vertex_b);
          mismatch_count++;
        end
        if (out_data.vertex_c !== want.vertex_c) begin
          $error("field vertex_c: expected %0h, got %0h", want.vertex_c, out_data.vertex_c);
          mismatch_count++;
        end
        if (out_data.truncated !== want.truncated) begin
          $error("field truncated: expected %0h, got %0h", want.truncated, out_data.truncated);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t owed;
  } dir_row_t;

  dir_row_t   dir_rows[$];
  logic [7:0] dir_bytes [0:29];

  initial begin
    dir_row_t    row;
    out_word_t   end_cut, end_clean;
    int          items_sent;
    int          table_no;
    int          setting_no;
    int          body;
    logic [15:0] new_parts, new_verts;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    mismatch_count = 0;
    quiet        = 1'b0;
    sender_gaps  = 1'b1;
    hold_results = 1'b0;
    cfg_parts    = '0;
    cfg_verts    = '0;
    clear_parse_state();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: one partition, 3 vertices, 1 triangle, every region
    // empty, then the triple 0,1,2 closing on the last byte.
    cfg_write(REG_PARTITION_COUNT, 16'd1);
    cfg_write(REG_VERTEX_COUNT, 16'd3);

    end_cut   = '0;
    end_cut.kind = KIND_END;
    end_cut.truncated = 1'b1;
    end_clean = '0;
    end_clean.kind = KIND_END;

    dir_bytes = '{
      8'h03, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, // counts
      8'h00, 8'h00, 8'h00, 8'h00,                                           // flags
      8'hFF, 8'h80, 8'h7F, 8'h01, 8'h55, 8'hAA, 8'hFE, 8'h00, 8'h10, 8'hC3, // tail
      8'h00, 8'h00, 8'h01, 8'h00, 8'h02, 8'h00                              // triple
    };

    // A lone last byte ends the table half way into the first count.
    row.w.data_byte = 8'hFF;
    row.w.last_byte = 1'b1;
    row.typed = 1'b1;
    row.owed  = end_cut;
    dir_rows.insert(dir_rows.size(), row);
    for (int i = 0; i < 30; i++) begin
      row.w.data_byte = dir_bytes[i];
      row.w.last_byte = (i == 29);
      row.typed = (i == 29);   // triangle comes from the model, end report is clean
      row.owed  = end_clean;
      dir_rows.insert(dir_rows.size(), row);
    end
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].owed);

    // Random tables, register settings changed every few tables while idle.
    items_sent = 0;
    table_no   = 0;
    setting_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (table_no % 4 == 0) begin
        drain();
        case (setting_no)
          0:       begin new_parts = 16'd0;     new_verts = 16'd0;     end
          1:       begin new_parts = 16'd2;     new_verts = 16'd100;   end
          2:       begin new_parts = 16'hFFFF;  new_verts = 16'hFFFF;  end
          3:       begin new_parts = 16'd3;     new_verts = 16'd7;     end
          4:       begin new_parts = 16'd1;     new_verts = 16'd1;     end
          5:       begin new_parts = 16'd4;     new_verts = 16'hFFFF;  end
          default: begin
            new_parts = 16'($urandom_range(0, 5));
            new_verts = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 20))
                                                     : 16'($urandom);
          end
        endcase
        cfg_write(REG_PARTITION_COUNT, new_parts);
        cfg_write(REG_VERTEX_COUNT, new_verts);
        // Dense triangle traffic here: let the result side sit still for a
        // long stretch so both queues fill and the input stalls.
        if (setting_no == 2) hold_results = 1'b1;
        setting_no++;
      end
      quiet       = (items_sent >= RANDOM_ITEMS - QUIET_ITEMS);
      sender_gaps = ($urandom_range(0, 2) != 0);
      body = build_table();
      items_sent += body;
      foreach (table_words[i]) send_word(table_words[i], 1'b0, '0);
      table_no++;
    end

    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_skin_partition_triangle_parser: done, clean");
    end else begin
      $display("tb_skin_partition_triangle_parser: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/spt_pkg.sv
hw/rtl/spt_front.sv
hw/rtl/spt_parser.sv
hw/rtl/spt_result_queue.sv
hw/rtl/skin_partition_triangle_parser.sv
verif/tb_skin_partition_triangle_parser.sv
